/* design/dbs_pkg.sv */
// ----------------------------------------------------------------------------
// dbs_pkg: shared constants, types and helpers of the deque/bag store
// Sizing of the entry RAM, operation codes, result record, slot arithmetic.
// ----------------------------------------------------------------------------
package dbs_pkg;

   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;

   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // Port field widths
   localparam int OP_BITS    = 3;
   localparam int ITEM_BITS  = 32;
   localparam int OUT_BITS   = 32;
   localparam int CNT_BITS   = 5;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 72;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CONTAINS   = 3'd4,
      OP_REMOVE     = 3'd5
   } op_type;

   typedef struct packed {
      logic                error_flag;
      logic [CNT_BITS-1:0] entry_count;
      logic [OUT_BITS-1:0] back_value;
      logic [OUT_BITS-1:0] front_value;
      logic                found;
   } rslt_type;

   // Physical slot of a logical position; pos stays below twice the capacity
   function automatic logic [ADDR_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] head,
                                                    input logic [COUNT_BITS-1:0] pos);
      logic [COUNT_BITS:0] sum;
      sum = (COUNT_BITS + 1)'(head) + (COUNT_BITS + 1)'(pos);
      if (sum >= (COUNT_BITS + 1)'(CAPACITY)) begin
         sum = sum - (COUNT_BITS + 1)'(CAPACITY);
      end
      return ADDR_BITS'(sum);
   endfunction

   // Sign-extend (or truncate) a stored value to the result field width
   function automatic logic [OUT_BITS-1:0] sext_out(input logic [VALUE_BITS-1:0] v);
      return OUT_BITS'($signed(v));
   endfunction

endpackage

/* design/dbs_ram.sv */
// ----------------------------------------------------------------------------
// dbs_ram: simple dual-port RAM
// One write port, one read port, read data registered (valid in the cycle after the address).
// ----------------------------------------------------------------------------
module dbs_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dbs_ctrl.sv */
// ----------------------------------------------------------------------------
// dbs_ctrl: operation sequencer of the deque/bag store
// Updates pointers, scans and compacts the entry RAM, then reads the front
// and back entries and hands one result record to the output stage.
// ----------------------------------------------------------------------------
module dbs_ctrl
   import dbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [OP_BITS-1:0]    in_op,
   input  logic [ITEM_BITS-1:0]  in_value,
   // entry RAM
   output logic                  wr_en,
   output logic [ADDR_BITS-1:0]  wr_addr,
   output logic [VALUE_BITS-1:0] wr_data,
   output logic [ADDR_BITS-1:0]  rd_addr,
   input  logic [VALUE_BITS-1:0] rd_data,
   // result side
   output logic                  res_valid,
   input  logic                  res_ready,
   output rslt_type              res
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_FRONT = 6'b001000,
      ST_BACK  = 6'b010000,
      ST_EMIT  = 6'b100000
   } st_type;

   st_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]  head_ff, head_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   op_type                op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  found_ff, found_in;
   logic                  err_ff, err_in;
   logic [COUNT_BITS-1:0] iss_ff, iss_in;
   logic                  pend_ff, pend_in;
   logic [COUNT_BITS-1:0] pidx_ff, pidx_in;
   logic [COUNT_BITS-1:0] sh_ff, sh_in;
   logic                  wpend_ff, wpend_in;
   logic [ADDR_BITS-1:0]  widx_ff, widx_in;
   logic [VALUE_BITS-1:0] front_ff, front_in;

   logic                  full;
   logic                  empty;
   logic [ADDR_BITS-1:0]  head_dec;
   logic [ADDR_BITS-1:0]  head_inc;
   logic [COUNT_BITS-1:0] back_pos;
   logic [ADDR_BITS-1:0]  back_slot;
   logic [VALUE_BITS-1:0] req_val;
   logic                  issue;
   logic                  hit;
   logic [COUNT_BITS-1:0] sh_next;
   logic                  more;

   assign full      = (cnt_ff == COUNT_BITS'(CAPACITY));
   assign empty     = (cnt_ff == '0);
   assign head_dec  = (head_ff == '0) ? ADDR_BITS'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc  = (head_ff == ADDR_BITS'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   assign back_pos  = empty ? '0 : cnt_ff - 1'b1;
   assign back_slot = slot_of(head_ff, back_pos);
   assign req_val   = VALUE_BITS'(in_value);
   assign issue     = (iss_ff < cnt_ff);
   assign hit       = pend_ff && (rd_data == val_ff);
   assign sh_next   = sh_ff + 1'b1;
   assign more      = (sh_next < cnt_ff);

   assign in_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      found_in  = found_ff;
      err_in    = err_ff;
      iss_in    = iss_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      sh_in     = sh_ff;
      wpend_in  = wpend_ff;
      widx_in   = widx_ff;
      front_in  = front_ff;
      wr_en     = 1'b0;
      wr_addr   = widx_ff;
      wr_data   = rd_data;
      rd_addr   = back_slot;
      res_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               op_in    = op_type'(in_op);
               val_in   = req_val;
               found_in = 1'b0;
               err_in   = 1'b0;
               iss_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_FRONT;
               case (op_type'(in_op))
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        err_in = 1'b1;
                     end else begin
                        head_in = head_dec;
                        cnt_in  = cnt_ff + 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        wr_data = req_val;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        err_in = 1'b1;
                     end else begin
                        cnt_in  = cnt_ff + 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = slot_of(head_ff, cnt_ff);
                        wr_data = req_val;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        err_in = 1'b1;
                     end else begin
                        head_in = head_inc;
                        cnt_in  = cnt_ff - 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        err_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff - 1'b1;
                     end
                  end
                  OP_CONTAINS, OP_REMOVE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Stream reads from the front; compare each word in the cycle after its read
         ST_SCAN: begin
            rd_addr = slot_of(head_ff, iss_ff);
            if (hit) begin
               found_in = 1'b1;
               pend_in  = 1'b0;
               if (op_ff == OP_REMOVE) begin
                  sh_in    = pidx_ff;
                  wpend_in = 1'b0;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FRONT;
               end
            end else if (!issue) begin
               pend_in  = 1'b0;
               state_in = ST_FRONT;
            end else begin
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
               pidx_in = iss_ff;
            end
         end

         // Close the gap: read position j+1, write it to position j next cycle
         ST_SHIFT: begin
            wr_en = wpend_ff;
            if (more) begin
               rd_addr  = slot_of(head_ff, sh_next);
               widx_in  = slot_of(head_ff, sh_ff);
               wpend_in = 1'b1;
               sh_in    = sh_next;
            end else begin
               wpend_in = 1'b0;
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_FRONT;
            end
         end

         ST_FRONT: begin
            rd_addr  = head_ff;
            state_in = ST_BACK;
         end

         ST_BACK: begin
            front_in = rd_data;
            state_in = ST_EMIT;
         end

         // Back entry read stays on the RAM output while the result waits
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.found       = found_ff;
      res.error_flag  = err_ff;
      res.entry_count = CNT_BITS'(cnt_ff);
      res.front_value = empty ? '0 : sext_out(front_ff);
      res.back_value  = empty ? '0 : sext_out(rd_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         wpend_ff <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      found_ff <= found_in;
      err_ff   <= err_in;
      iss_ff   <= iss_in;
      pidx_ff  <= pidx_in;
      sh_ff    <= sh_in;
      widx_ff  <= widx_in;
      front_ff <= front_in;
   end

endmodule

/* design/deque_bag_store.sv */
// ----------------------------------------------------------------------------
// deque_bag_store: bounded double-ended queue with membership search
// Push/pop at either end, contains test and remove-first-match with gap
// closing; every request transaction yields one response transaction.
// ----------------------------------------------------------------------------
//
//   channel | ports      | transaction carries
//   --------+------------+---------------------------------------------------
//   request | req_t*     | operation (tuser), item_value (tdata)
//   result  | rsp_t*     | found, front/back value, entry count, error flag
//
// Sequence: push, pop and unused codes step through accept, front read,
// back read and emit before the next acceptance. Contains adds a scan
// from the front that ends at the first match or past the last entry.
// Remove adds the same scan, then a shift step for each entry behind the
// match and a finishing step, in series on the single RAM read port.
// Reset clears head pointer, count and sequencer; RAM contents are not
// cleared. A stalled result holds in the output register; the sequencer
// accepts the next transaction meanwhile and waits in emit only if the
// register is still full.
//
module deque_bag_store
   import dbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [31:0] item_value
   input  logic [OP_BITS-1:0]       req_tuser,  // [2:0] operation
   // result
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // [0] found, [32:1] front_value,
                                                // [64:33] back_value,
                                                // [69:65] entry_count,
                                                // [70] error_flag, [71] zero
);

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic                  res_valid;
   logic                  res_ready;
   rslt_type              res;

   logic                  out_vld_ff, out_vld_in;
   rslt_type              out_ff, out_in;

   // Entry storage: circular buffer indexed by the sequencer
   dbs_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Operation sequencer: pointer updates, scan, compaction, end reads
   dbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_value  (req_tdata[ITEM_BITS-1:0]),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: load when empty or being drained this cycle
   assign res_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (res_valid && res_ready) begin
         out_vld_in = 1'b1;
         out_in     = res;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // Pack the result record, lowest field first, padded to whole bytes
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_ff);

endmodule

/* sim/deque_bag_store_checker.sv */
// ----------------------------------------------------------------------------
// deque_bag_store_checker: response predictor and comparator
// Watches both stream channels of the deque/bag store. It keeps its own copy
// of the ring of entries, predicts one status per request transaction and
// compares every response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_bag_store_checker
   import dbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [OP_BITS-1:0]       req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output int                       fail_count,
   output int                       pending_count,
   output int                       checked_count,
   output int                       hit_count,
   output int                       reject_count
);

   logic [VALUE_BITS-1:0] ring [CAPACITY];
   int                    head_pos;
   int                    depth;
   rslt_type              status_q [$];

   function automatic int ring_slot(input int offset);
      return (head_pos + offset) % CAPACITY;
   endfunction

   // Apply one operation to the shadow store and return the status it gives
   function automatic rslt_type next_status(input logic [OP_BITS-1:0] code,
                                            input logic [ITEM_BITS-1:0] item);
      rslt_type              s;
      logic [VALUE_BITS-1:0] v;
      int                    match;
      int                    i;
      s     = '0;
      v     = item[VALUE_BITS-1:0];
      match = -1;
      case (code)
         OP_PUSH_FRONT: begin
            if (depth == CAPACITY) s.error_flag = 1'b1;
            else begin
               head_pos       = (head_pos + CAPACITY - 1) % CAPACITY;
               ring[head_pos] = v;
               depth++;
            end
         end
         OP_PUSH_BACK: begin
            if (depth == CAPACITY) s.error_flag = 1'b1;
            else begin
               ring[ring_slot(depth)] = v;
               depth++;
            end
         end
         OP_POP_FRONT: begin
            if (depth == 0) s.error_flag = 1'b1;
            else begin
               head_pos = (head_pos + 1) % CAPACITY;
               depth--;
            end
         end
         OP_POP_BACK: begin
            if (depth == 0) s.error_flag = 1'b1;
            else depth--;
         end
         OP_CONTAINS, OP_REMOVE: begin
            for (i = 0; i < depth && match < 0; i++) begin
               if (ring[ring_slot(i)] == v) match = i;
            end
            s.found = (match >= 0);
            // close the gap: later entries move one place toward the front
            if (code == OP_REMOVE && match >= 0) begin
               for (i = match; i + 1 < depth; i++) begin
                  ring[ring_slot(i)] = ring[ring_slot(i + 1)];
               end
               depth--;
            end
         end
         default: ;
      endcase
      if (depth > 0) begin
         s.front_value = OUT_BITS'($signed(ring[ring_slot(0)]));
         s.back_value  = OUT_BITS'($signed(ring[ring_slot(depth - 1)]));
      end
      s.entry_count = CNT_BITS'(depth);
      return s;
   endfunction

   always @(posedge clock) begin
      rslt_type want;
      rslt_type got;
      if (reset) begin
         status_q.delete();
         head_pos      = 0;
         depth         = 0;
         fail_count    <= 0;
         pending_count <= 0;
         checked_count <= 0;
         hit_count     <= 0;
         reject_count  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_q.push_back(next_status(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got           = rslt_type'(rsp_tdata[RSP_DATA_BITS-2:0]);
            checked_count <= checked_count + 1;
            if (status_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("response with nothing outstanding: %h", rsp_tdata);
            end else begin
               want = status_q.pop_front();
               if (got.found !== want.found || got.front_value !== want.front_value ||
                   got.back_value !== want.back_value ||
                   got.entry_count !== want.entry_count ||
                   got.error_flag !== want.error_flag ||
                   rsp_tdata[RSP_DATA_BITS-1] !== 1'b0) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("mismatch: found %b/%b front %h/%h back %h/%h count %0d/%0d err %b/%b pad %b",
                              want.found, got.found, want.front_value, got.front_value,
                              want.back_value, got.back_value, want.entry_count,
                              got.entry_count, want.error_flag, got.error_flag,
                              rsp_tdata[RSP_DATA_BITS-1]);
                  end
               end
               if (want.found) hit_count <= hit_count + 1;
               if (want.error_flag) reject_count <= reject_count + 1;
            end
         end
         pending_count <= status_q.size();
      end
   end

endmodule

/* sim/tb_deque_bag_store.sv */
// ----------------------------------------------------------------------------
// tb_deque_bag_store: stimulus and verdict for the deque/bag store
// Drives a directed opening (empty-store errors, extreme values, duplicate
// removal, gap closing) and then random bursts that fill, drain or mix the
// store, under three back-pressure phases. Checking sits in the checker.
// ----------------------------------------------------------------------------
module tb_deque_bag_store;
   import dbs_pkg::*;

   // codes the block must treat as no-ops
   localparam logic [OP_BITS-1:0] CODE_SPARE_6 = 3'd6;
   localparam logic [OP_BITS-1:0] CODE_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS = 1050;
   localparam int BURST_LEN    = 24;
   localparam int DRAIN_CYCLES = 48;      // beyond a full-length removal
   localparam int CYCLE_LIMIT  = 300000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;   // [31:0] item_value
   logic [OP_BITS-1:0]       req_tuser  = '0;   // [2:0] operation
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // [0] found, [32:1] front_value,
                                                // [64:33] back_value,
                                                // [69:65] entry_count,
                                                // [70] error_flag, [71] zero

   int fail_count;
   int pending_count;
   int checked_count;
   int hit_count;
   int reject_count;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int sent_count  = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   deque_bag_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deque_bag_store_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .hit_count     (hit_count),
      .reject_count  (reject_count)
   );

   // Receiver: stall the response channel at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one request transaction, idling first at the current rate, and
   // hold it until the block accepts it
   task automatic send(input logic [OP_BITS-1:0] code, input logic [ITEM_BITS-1:0] item);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Hold off the sender until every outstanding response has been seen;
   // the first edge lets the count take in the last accepted request
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Favour a small set of values so that searches and removals hit often,
   // including duplicates; mix in the extremes and fully random words
   function automatic logic [ITEM_BITS-1:0] draw_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '1;
         3:       return '0;
         4, 5, 6: return ITEM_BITS'($urandom_range(9));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_BITS-1:0] draw_operation(input mix_type mix);
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) return CODE_SPARE_6;
      if (roll < 4) return CODE_SPARE_7;
      case (mix)
         MIX_FILL: begin
            if (roll < 75) return roll[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
            if (roll < 85) return OP_CONTAINS;
            if (roll < 95) return OP_REMOVE;
            return roll[0] ? OP_POP_BACK : OP_POP_FRONT;
         end
         MIX_DRAIN: begin
            if (roll < 54) return roll[0] ? OP_POP_BACK : OP_POP_FRONT;
            if (roll < 78) return OP_REMOVE;
            if (roll < 90) return OP_CONTAINS;
            return roll[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end
         default: return OP_BITS'($urandom_range(int'(OP_REMOVE), int'(OP_PUSH_FRONT)));
      endcase
   endfunction

   initial begin
      mix_type mix;
      int      phase;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: errors and searches on an empty store
      send(OP_POP_FRONT, 32'h0000_0000);
      send(OP_POP_BACK,  32'hFFFF_FFFF);
      send(OP_CONTAINS,  32'h0000_0000);
      send(OP_REMOVE,    32'h0000_0000);
      send(CODE_SPARE_6, 32'hFFFF_FFFF);
      send(CODE_SPARE_7, 32'h8000_0000);
      // build [-1, MIN, 0x7FFFFFFF, 0, 0x7FFFFFFF] with both push ends
      send(OP_PUSH_FRONT, 32'h8000_0000);
      send(OP_PUSH_BACK,  32'h7FFF_FFFF);
      send(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send(OP_PUSH_BACK,  32'h0000_0000);
      send(OP_PUSH_BACK,  32'h7FFF_FFFF);
      send(OP_CONTAINS,   32'hFFFF_FFFF);
      send(OP_CONTAINS,   32'h1234_5678);
      // first match sits mid-store: later entries must close the gap
      send(OP_REMOVE,     32'h7FFF_FFFF);
      send(OP_REMOVE,     32'h7FFF_FFFF);
      send(OP_REMOVE,     32'h1234_5678);
      send(OP_CONTAINS,   32'h7FFF_FFFF);
      send(OP_POP_FRONT,  32'hA5A5_A5A5);
      send(OP_POP_BACK,   32'h5A5A_5A5A);
      send(OP_POP_BACK,   32'h0000_0000);
      send(OP_POP_FRONT,  32'h0000_0000);
      settle();

      // Random bursts; push-heavy bursts reach the full store, pop-heavy
      // ones the empty store. Back-pressure changes with each phase.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin idle_pct = 16; stall_pct = 79; end
            1: begin idle_pct = 79; stall_pct = 16; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         while (sent_count < 21 + (phase + 1) * RANDOM_ITEMS / 3) begin
            mix = mix_type'($urandom_range(int'(MIX_EVEN), int'(MIX_FILL)));
            repeat (BURST_LEN) send(draw_operation(mix), draw_value());
            if ($urandom_range(19) == 0) settle();
         end
         settle();
      end

      // Drain: let any stray response surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request transactions through three back-pressure phases,",
               sent_count);
      $display("%0d responses compared, %0d found a value, %0d refused at full or empty",
               checked_count, hit_count, reject_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
